// ===== rtl/ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// ptw_pkg: shared types and constants of the page table walker
// queue entry layout, result kinds and walk level codes
// ----------------------------------------------------------------------------
package ptw_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam int unsigned VpnW   = 36;
  localparam int unsigned IdxW   = 9;
  localparam int unsigned LevelW = 3;

  localparam logic [LevelW-1:0] LvlIdle = 3'd0;
  localparam logic [LevelW-1:0] Lvl1    = 3'd1;
  localparam logic [LevelW-1:0] Lvl2    = 3'd2;
  localparam logic [LevelW-1:0] Lvl3    = 3'd3;
  localparam logic [LevelW-1:0] Lvl4    = 3'd4;

  localparam logic [63:0] TableMask = ~64'h0fff;
  localparam logic [63:0] BigMask   = ~64'h1fff;
  localparam logic [63:0] LeafMask  = ~64'h01ff;
  localparam int unsigned BigBit    = 7;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_REFUSE = 2'd2
  } kind_e;

  typedef enum logic {
    OP_START = 1'b0,
    OP_REPLY = 1'b1
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [63:0]      word;  // table root on start, table entry on reply
    logic [VpnW-1:0]  vpn;
  } entry_t;

endpackage

// ===== rtl/four_level_page_table_walker.sv =====
// ----------------------------------------------------------------------------
// four_level_page_table_walker: four-level page table walk engine
// translates a 48-bit virtual address by issuing table reads and folding replies
// ----------------------------------------------------------------------------
// usage
//   input channel: one beat per item, mode_i low starts a walk (virt_addr_i,
//   table_root_i), mode_i high returns the table word of the last read request
//   (table_word_i); a beat is taken when in_valid_i is high and in_stall_o low
//   output channel: one beat per input item, kind_o tells a read request
//   (read_addr_o), a finished walk (phys_addr_o, mapped_o) or a refused item
//   path: the front classifies an accepted input beat into the queue, then the
//   walk engine registers its result into the output reg
//   throughput: one item per cycle while out_stall_i is low, set by the walk
//   engine that does one 64-bit mask-and-add per item
//   stall: when out_stall_i holds, the output reg keeps its beat and the two
//   entry queue absorbs up to two more items before in_stall_o rises
//   reset: rst_ni low clears the queue, the output valid and the walk level,
//   so the walker is idle and the first reply is refused
// ----------------------------------------------------------------------------
module four_level_page_table_walker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic         mode_i,
  input  logic [47:0]  virt_addr_i,
  input  logic [63:0]  table_root_i,
  input  logic [63:0]  table_word_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [1:0]   kind_o,
  output logic [63:0]  read_addr_o,
  output logic [63:0]  phys_addr_o,
  output logic         mapped_o
);

  ptw_pkg::entry_t front_entry;  // classified input beat
  ptw_pkg::entry_t head_entry;   // oldest queued item
  logic            q_full;
  logic            head_valid;
  logic            pop;

  // front: classify start vs reply
  ptw_front u_front (
    .mode_i       (mode_i),
    .virt_addr_i  (virt_addr_i),
    .table_root_i (table_root_i),
    .table_word_i (table_word_i),
    .entry_o      (front_entry)
  );

  // decoupling queue, its full flag is the input stall
  ptw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_valid_i),
    .push_entry_i (front_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_entry_o (head_entry)
  );

  assign in_stall_o = q_full;

  // back: walk state and registered result
  ptw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_entry_i (head_entry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .read_addr_o  (read_addr_o),
    .phys_addr_o  (phys_addr_o),
    .mapped_o     (mapped_o)
  );

endmodule

// ===== rtl/ptw_front.sv =====
// ----------------------------------------------------------------------------
// ptw_front: input side of the page table walker
// classifies each beat as a walk start or a table reply and builds a queue entry
// ----------------------------------------------------------------------------
module ptw_front (
  input  logic               mode_i,
  input  logic [47:0]        virt_addr_i,
  input  logic [63:0]        table_root_i,
  input  logic [63:0]        table_word_i,
  output ptw_pkg::entry_t    entry_o
);

  always_comb begin
    entry_o = '0;
    if (mode_i == 1'b0) begin
      entry_o.op   = ptw_pkg::OP_START;
      entry_o.word = table_root_i;
      entry_o.vpn  = virt_addr_i[47:12];
    end else begin
      entry_o.op   = ptw_pkg::OP_REPLY;
      entry_o.word = table_word_i;
    end
  end

endmodule

// ===== rtl/ptw_queue.sv =====
// ----------------------------------------------------------------------------
// ptw_queue: short fifo between front and back
// lets the input side keep taking beats while the back end is stalled
// ----------------------------------------------------------------------------
module ptw_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ptw_pkg::entry_t    push_entry_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               head_valid_o,
  output ptw_pkg::entry_t    head_entry_o
);

  ptw_pkg::entry_t                   mem_q [ptw_pkg::QueueDepth];
  logic [ptw_pkg::QueuePtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [ptw_pkg::QueuePtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [ptw_pkg::QueueCntW-1:0]     cnt_q, cnt_d;
  logic                              do_push, do_pop;

  assign full_o       = (cnt_q == ptw_pkg::QueueCntW'(ptw_pkg::QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_entry_o = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  function automatic logic [ptw_pkg::QueuePtrW-1:0] ptr_inc(
    input logic [ptw_pkg::QueuePtrW-1:0] p
  );
    if (p == ptw_pkg::QueuePtrW'(ptw_pkg::QueueDepth - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage is payload only
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ===== rtl/ptw_back.sv =====
// ----------------------------------------------------------------------------
// ptw_back: walk engine of the page table walker
// holds the walk level and page number, forms one result per queue entry
// ----------------------------------------------------------------------------
module ptw_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  ptw_pkg::entry_t    head_entry_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [63:0]        read_addr_o,
  output logic [63:0]        phys_addr_o,
  output logic               mapped_o
);

  logic [ptw_pkg::LevelW-1:0] level_q, level_d;
  logic [ptw_pkg::VpnW-1:0]   vpn_q, vpn_d;
  logic                       out_valid_q;
  ptw_pkg::kind_e             kind_q, kind_d;
  logic [63:0]                read_addr_q, read_addr_d;
  logic [63:0]                phys_addr_q, phys_addr_d;
  logic                       mapped_q, mapped_d;
  logic                       busy;
  logic [ptw_pkg::IdxW-1:0]   next_idx;
  logic [63:0]                base;

  assign pop_o = head_valid_i && (!out_valid_q || !out_stall_i);
  assign busy  = (level_q inside {[ptw_pkg::Lvl1:ptw_pkg::Lvl4]});

  // index of the level about to be read
  always_comb begin
    case (level_q)
      ptw_pkg::Lvl1: next_idx = vpn_q[26:18];
      ptw_pkg::Lvl2: next_idx = vpn_q[17:9];
      ptw_pkg::Lvl3: next_idx = vpn_q[8:0];
      default:       next_idx = head_entry_i.vpn[35:27];
    endcase
  end

  assign base = head_entry_i.word & ptw_pkg::TableMask;

  always_comb begin
    level_d     = level_q;
    vpn_d       = vpn_q;
    kind_d      = ptw_pkg::KIND_REFUSE;
    read_addr_d = '0;
    phys_addr_d = '0;
    mapped_d    = 1'b0;
    case (head_entry_i.op)
      ptw_pkg::OP_START: begin
        if (!busy) begin
          vpn_d       = head_entry_i.vpn;
          level_d     = ptw_pkg::Lvl1;
          kind_d      = ptw_pkg::KIND_READ;
          read_addr_d = base + {52'd0, next_idx, 3'd0};
        end
      end
      ptw_pkg::OP_REPLY: begin
        if (busy) begin
          if (level_q == ptw_pkg::Lvl4) begin
            level_d     = ptw_pkg::LvlIdle;
            kind_d      = ptw_pkg::KIND_DONE;
            phys_addr_d = head_entry_i.word & ptw_pkg::LeafMask;
            mapped_d    = |head_entry_i.word;
          end else if (head_entry_i.word == '0) begin
            // empty entry ends the walk unmapped
            level_d = ptw_pkg::LvlIdle;
            kind_d  = ptw_pkg::KIND_DONE;
          end else if (level_q == ptw_pkg::Lvl3 && head_entry_i.word[ptw_pkg::BigBit]) begin
            // large page
            level_d     = ptw_pkg::LvlIdle;
            kind_d      = ptw_pkg::KIND_DONE;
            phys_addr_d = head_entry_i.word & ptw_pkg::BigMask;
            mapped_d    = 1'b1;
          end else begin
            level_d     = level_q + 1'b1;
            kind_d      = ptw_pkg::KIND_READ;
            read_addr_d = base + {52'd0, next_idx, 3'd0};
          end
        end
      end
      default: begin
        kind_d = ptw_pkg::KIND_REFUSE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= ptw_pkg::LvlIdle;
      vpn_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        level_q     <= level_d;
        vpn_q       <= vpn_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q      <= kind_d;
      read_addr_q <= read_addr_d;
      phys_addr_q <= phys_addr_d;
      mapped_q    <= mapped_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign read_addr_o = read_addr_q;
  assign phys_addr_o = phys_addr_q;
  assign mapped_o    = mapped_q;

endmodule

// ===== rtl/ptw_checker.sv =====
// ----------------------------------------------------------------------------
// ptw_checker: port-level checks of the page table walker
// result encoding rules and output hold under stall, bound to the top level
// ----------------------------------------------------------------------------
module ptw_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         out_valid_o,
  input  logic         out_stall_i,
  input  logic [1:0]   kind_o,
  input  logic [63:0]  read_addr_o,
  input  logic [63:0]  phys_addr_o,
  input  logic         mapped_o
);

  // a stalled output beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped under stall");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o == ptw_pkg::KIND_READ || kind_o == ptw_pkg::KIND_DONE ||
                     kind_o == ptw_pkg::KIND_REFUSE))
    else $error("illegal result kind");

  // table entries are 8-byte aligned
  a_read_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == ptw_pkg::KIND_READ |-> read_addr_o[2:0] == 3'd0)
    else $error("misaligned table read");

  a_done_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != ptw_pkg::KIND_READ |-> read_addr_o == '0)
    else $error("read address on non-read result");

  a_mapped_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != ptw_pkg::KIND_DONE |-> !mapped_o && phys_addr_o == '0)
    else $error("translation fields on non-done result");

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .kind_o      (kind_o),
  .read_addr_o (read_addr_o),
  .phys_addr_o (phys_addr_o),
  .mapped_o    (mapped_o)
);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the four-level page table walker
// a directed table is walked first: extremes, refusals, zero entries, 2M pages
// and leaf words. Random walks with random table words follow. Every output
// beat is checked against its typed-in expectation or a cycle-free predictor
// of the walk, with idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned DirRows       = 25;
  localparam int unsigned RandItems     = 2000;
  localparam int unsigned CalmFrom      = 1700;  // no idling from here on
  localparam int unsigned PhaseLen      = 250;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned MaxPrinted    = 40;

  // one expected output beat
  typedef struct {
    ptw_pkg::kind_e kind;
    logic [63:0]    read_addr;
    logic [63:0]    phys_addr;
    logic           mapped;
  } walk_result_t;

  // one row of the directed table, fixed marks a typed-in expectation
  typedef struct {
    ptw_pkg::op_e op;
    logic [47:0]  va;
    logic [63:0]  root;
    logic [63:0]  word;
    bit           fixed;
    walk_result_t res;
  } dir_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         in_valid_i;
  logic         in_stall_o;
  logic         mode_i;
  logic [47:0]  virt_addr_i;
  logic [63:0]  table_root_i;
  logic [63:0]  table_word_i;
  logic         out_valid_o;
  logic         out_stall_i;
  logic [1:0]   kind_o;
  logic [63:0]  read_addr_o;
  logic [63:0]  phys_addr_o;
  logic         mapped_o;

  four_level_page_table_walker dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .virt_addr_i  (virt_addr_i),
    .table_root_i (table_root_i),
    .table_word_i (table_word_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .read_addr_o  (read_addr_o),
    .phys_addr_o  (phys_addr_o),
    .mapped_o     (mapped_o)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // walk predictor: own copy of the level and the saved page number
  // ---------------------------------------------------------------------------
  logic [ptw_pkg::LevelW-1:0] model_level = ptw_pkg::LvlIdle;
  logic [ptw_pkg::VpnW-1:0]   model_vpn   = '0;

  walk_result_t pending_results_q [$];
  dir_row_t     dir_tab [DirRows];

  int unsigned mismatches   = 0;
  int unsigned beats_in     = 0;
  int unsigned beats_out    = 0;
  int unsigned reads_seen   = 0;
  int unsigned mapped_seen  = 0;
  int unsigned unmapped_seen = 0;
  int unsigned refused_seen = 0;

  // idling control shared by both channels
  bit          idle_en  = 1'b1;
  int unsigned gap_pct  = 20;
  int unsigned stall_pct = 20;

  // entry address inside the table at base for the given level
  function automatic logic [63:0] table_entry_addr(logic [63:0] base,
                                                   logic [ptw_pkg::LevelW-1:0] lvl);
    logic [ptw_pkg::VpnW-1:0] shifted;
    logic [ptw_pkg::IdxW-1:0] idx;
    shifted = model_vpn >> ((4 - int'(lvl)) * ptw_pkg::IdxW);
    idx     = shifted[ptw_pkg::IdxW-1:0];
    return (base & ptw_pkg::TableMask) + (64'(idx) << 3);
  endfunction

  // one walk step, advances the model state
  function automatic walk_result_t predict_walk_step(ptw_pkg::op_e op,
                                                     logic [47:0] va,
                                                     logic [63:0] root,
                                                     logic [63:0] word);
    walk_result_t r;
    logic         busy;
    r.kind      = ptw_pkg::KIND_REFUSE;
    r.read_addr = '0;
    r.phys_addr = '0;
    r.mapped    = 1'b0;
    // codes 5..7 count as idle
    busy = (model_level >= ptw_pkg::Lvl1) && (model_level <= ptw_pkg::Lvl4);
    if (op == ptw_pkg::OP_START) begin
      if (!busy) begin
        model_vpn   = va[47:12];
        model_level = ptw_pkg::Lvl1;
        r.kind      = ptw_pkg::KIND_READ;
        r.read_addr = table_entry_addr(root, ptw_pkg::Lvl1);
      end
    end else if (busy) begin
      if (model_level == ptw_pkg::Lvl4) begin
        // leaf: mapped whenever the word is nonzero, even if masked to zero
        model_level = ptw_pkg::LvlIdle;
        r.kind      = ptw_pkg::KIND_DONE;
        r.phys_addr = word & ptw_pkg::LeafMask;
        r.mapped    = (word != '0);
      end else if (word == '0) begin
        // zero entry ends the walk unmapped
        model_level = ptw_pkg::LvlIdle;
        r.kind      = ptw_pkg::KIND_DONE;
      end else if (model_level == ptw_pkg::Lvl3 && word[ptw_pkg::BigBit]) begin
        // 2M page, no range check
        model_level = ptw_pkg::LvlIdle;
        r.kind      = ptw_pkg::KIND_DONE;
        r.phys_addr = word & ptw_pkg::BigMask;
        r.mapped    = 1'b1;
      end else begin
        model_level = model_level + 1'b1;
        r.kind      = ptw_pkg::KIND_READ;
        r.read_addr = table_entry_addr(word, model_level);
      end
    end
    return r;
  endfunction

  function automatic dir_row_t mk_row(ptw_pkg::op_e op, logic [47:0] va,
                                      logic [63:0] root, logic [63:0] word,
                                      bit fixed, ptw_pkg::kind_e kind,
                                      logic [63:0] ra, logic [63:0] pa, logic m);
    dir_row_t row;
    row.op            = op;
    row.va            = va;
    row.root          = root;
    row.word          = word;
    row.fixed         = fixed;
    row.res.kind      = kind;
    row.res.read_addr = ra;
    row.res.phys_addr = pa;
    row.res.mapped    = m;
    return row;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // random burst length, zero when no gap this time
  function automatic int unsigned burst_len(int unsigned pct);
    if (idle_en && $urandom_range(99) < pct) begin
      return $urandom_range(12, 1);
    end
    return 0;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatches < MaxPrinted) begin
      $display("%0t mismatch on %s beat %0d: got %h want %h",
               $time, what, beats_out, got, want);
    end
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // input side: drive one beat, hold it until taken, then predict it
  // called at a rising edge and returns at the edge that took the beat
  // ---------------------------------------------------------------------------
  task automatic send_beat(dir_row_t row);
    walk_result_t pred;
    in_valid_i   <= 1'b1;
    mode_i       <= row.op;
    virt_addr_i  <= row.va;
    table_root_i <= row.root;
    table_word_i <= row.word;
    do @(posedge clk_i); while (in_stall_o);
    pred = predict_walk_step(row.op, row.va, row.root, row.word);
    // typed rows still advance the model so later rows stay in step
    pending_results_q.push_back(row.fixed ? row.res : pred);
    beats_in++;
  endtask

  // gap after a beat, valid drops only if there is one
  task automatic input_gap();
    int unsigned gap;
    gap = burst_len(gap_pct);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // random item, mostly well-formed walks shaped by the current level
  function automatic dir_row_t gen_item();
    dir_row_t    row;
    logic [63:0] va_bits;
    int unsigned sel;
    va_bits  = rand_word();
    row      = mk_row(ptw_pkg::OP_START, va_bits[47:0], rand_word(), rand_word(),
                      1'b0, ptw_pkg::KIND_READ, '0, '0, 1'b0);
    sel      = $urandom_range(99);
    if (model_level == ptw_pkg::LvlIdle) begin
      // a stray reply now and then is refused
      if (sel < 10) row.op = ptw_pkg::OP_REPLY;
    end else if (sel >= 6) begin
      row.op = ptw_pkg::OP_REPLY;
      sel    = $urandom_range(99);
      if (sel < 8) begin
        row.word = '0;
      end else if (model_level == ptw_pkg::Lvl3) begin
        row.word[ptw_pkg::BigBit] = (sel < 45);
      end else if (model_level == ptw_pkg::Lvl4 && sel < 25) begin
        // small leaf words mask to zero but still count as mapped
        row.word = 64'($urandom_range(511, 1));
      end
    end
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // output side: stall bursts
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_left = burst_len(stall_pct);
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output checker: each taken beat against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    walk_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results_q.size() == 0) begin
        report_mismatch("unexpected", 64'(kind_o), '0);
      end else begin
        want = pending_results_q.pop_front();
        if (kind_o !== want.kind)
          report_mismatch("kind", 64'(kind_o), 64'(want.kind));
        if (read_addr_o !== want.read_addr)
          report_mismatch("read_addr", read_addr_o, want.read_addr);
        if (phys_addr_o !== want.phys_addr)
          report_mismatch("phys_addr", phys_addr_o, want.phys_addr);
        if (mapped_o !== want.mapped)
          report_mismatch("mapped", 64'(mapped_o), 64'(want.mapped));
        case (want.kind)
          ptw_pkg::KIND_READ: reads_seen++;
          ptw_pkg::KIND_DONE: begin
            if (want.mapped) mapped_seen++;
            else unmapped_seen++;
          end
          default: refused_seen++;
        endcase
      end
      beats_out++;
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: cycles without any beat on either channel
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("timeout after %0d quiet cycles, %0d results outstanding",
                   quiet_cycles, pending_results_q.size());
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned pick;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    mode_i       = ptw_pkg::OP_START;
    virt_addr_i  = '0;
    table_root_i = '0;
    table_word_i = '0;

    // directed table: typed rows are obvious from the walk rules
    dir_tab[0]  = mk_row(ptw_pkg::OP_REPLY, '0, '0, '1, 1'b1, ptw_pkg::KIND_REFUSE,
                         '0, '0, 1'b0);                                    // reply idle
    dir_tab[1]  = mk_row(ptw_pkg::OP_START, '1, '1, '0, 1'b1, ptw_pkg::KIND_READ,
                         64'hffff_ffff_ffff_fff8, '0, 1'b0);
    dir_tab[2]  = mk_row(ptw_pkg::OP_START, '0, '0, '0, 1'b1, ptw_pkg::KIND_REFUSE,
                         '0, '0, 1'b0);                                    // start busy
    dir_tab[3]  = mk_row(ptw_pkg::OP_REPLY, '0, '0, '1, 1'b1, ptw_pkg::KIND_READ,
                         64'hffff_ffff_ffff_fff8, '0, 1'b0);
    dir_tab[4]  = mk_row(ptw_pkg::OP_REPLY, '0, '0, '1, 1'b1, ptw_pkg::KIND_READ,
                         64'hffff_ffff_ffff_fff8, '0, 1'b0);
    dir_tab[5]  = mk_row(ptw_pkg::OP_REPLY, '0, '0, '1, 1'b1, ptw_pkg::KIND_DONE,
                         '0, 64'hffff_ffff_ffff_e000, 1'b1);               // 2M page
    dir_tab[6]  = mk_row(ptw_pkg::OP_REPLY, '0, '0, '0, 1'b1, ptw_pkg::KIND_REFUSE,
                         '0, '0, 1'b0);
    dir_tab[7]  = mk_row(ptw_pkg::OP_START, '0, 64'h0fff, '0, 1'b1, ptw_pkg::KIND_READ,
                         '0, '0, 1'b0);
    dir_tab[8]  = mk_row(ptw_pkg::OP_REPLY, '0, '0, '0, 1'b1, ptw_pkg::KIND_DONE,
                         '0, '0, 1'b0);                                    // zero at 1
    dir_tab[9]  = mk_row(ptw_pkg::OP_START, '0, '0, '0, 1'b1, ptw_pkg::KIND_READ,
                         '0, '0, 1'b0);
    dir_tab[10] = mk_row(ptw_pkg::OP_REPLY, '0, '0, 64'h1000, 1'b1, ptw_pkg::KIND_READ,
                         64'h1000, '0, 1'b0);
    dir_tab[11] = mk_row(ptw_pkg::OP_REPLY, '0, '0, '0, 1'b1, ptw_pkg::KIND_DONE,
                         '0, '0, 1'b0);                                    // zero at 2
    dir_tab[12] = mk_row(ptw_pkg::OP_START, 48'h8040_2010_0fff, 64'h0000_00ab_cdef_1234,
                         '0, 1'b0, ptw_pkg::KIND_READ, '0, '0, 1'b0);
    dir_tab[13] = mk_row(ptw_pkg::OP_REPLY, '0, '0, 64'h0000_0000_0020_0abc, 1'b0,
                         ptw_pkg::KIND_READ, '0, '0, 1'b0);
    dir_tab[14] = mk_row(ptw_pkg::OP_REPLY, '0, '0, 64'h0000_0000_0030_0000, 1'b0,
                         ptw_pkg::KIND_READ, '0, '0, 1'b0);
    dir_tab[15] = mk_row(ptw_pkg::OP_REPLY, '0, '0, '0, 1'b1, ptw_pkg::KIND_DONE,
                         '0, '0, 1'b0);                                    // zero at 3
    dir_tab[16] = mk_row(ptw_pkg::OP_START, 48'h7fff_ffff_f000, 64'h8000_0000_0000_0000,
                         '0, 1'b0, ptw_pkg::KIND_READ, '0, '0, 1'b0);
    dir_tab[17] = mk_row(ptw_pkg::OP_REPLY, '0, '0, 64'h8000_0000_0000_0001, 1'b0,
                         ptw_pkg::KIND_READ, '0, '0, 1'b0);
    dir_tab[18] = mk_row(ptw_pkg::OP_REPLY, '0, '0, 64'h0000_1234_5678_9fff, 1'b0,
                         ptw_pkg::KIND_READ, '0, '0, 1'b0);
    dir_tab[19] = mk_row(ptw_pkg::OP_REPLY, '0, '0, 64'h80, 1'b1, ptw_pkg::KIND_DONE,
                         '0, '0, 1'b1);                                    // big bit only
    dir_tab[20] = mk_row(ptw_pkg::OP_START, 48'h0123_4567_89ab, '0, '0, 1'b0,
                         ptw_pkg::KIND_READ, '0, '0, 1'b0);
    dir_tab[21] = mk_row(ptw_pkg::OP_REPLY, '0, '0, 64'h1000, 1'b0, ptw_pkg::KIND_READ,
                         '0, '0, 1'b0);
    dir_tab[22] = mk_row(ptw_pkg::OP_REPLY, '0, '0, 64'h2000, 1'b0, ptw_pkg::KIND_READ,
                         '0, '0, 1'b0);
    dir_tab[23] = mk_row(ptw_pkg::OP_REPLY, '0, '0, 64'h7f, 1'b0, ptw_pkg::KIND_READ,
                         '0, '0, 1'b0);                                    // no big bit
    dir_tab[24] = mk_row(ptw_pkg::OP_REPLY, '0, '0, 64'h1ff, 1'b1, ptw_pkg::KIND_DONE,
                         '0, '0, 1'b1);                                    // leaf masks to 0

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_beat(dir_tab[i]);
      input_gap();
    end

    // random walks, idling pressure changes per phase
    for (int unsigned n = 0; n < RandItems; n++) begin
      if (n % PhaseLen == 0) begin
        pick      = $urandom_range(2);
        gap_pct   = (pick == 0) ? 0 : (pick == 1) ? 10 : 35;
        pick      = $urandom_range(2);
        stall_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 35;
      end
      if (n == CalmFrom) idle_en = 1'b0;
      send_beat(gen_item());
      input_gap();
    end
    in_valid_i <= 1'b0;

    // drain, the watchdog bounds this
    while (pending_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d items, got %0d beats: %0d reads, %0d mapped, %0d unmapped",
             beats_in, beats_out, reads_seen, mapped_seen, unmapped_seen);
    $display("%0d refused items, %0d mismatches", refused_seen, mismatches);
    if (mismatches == 0 && pending_results_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ptw_pkg.sv
rtl/ptw_front.sv
rtl/ptw_queue.sv
rtl/ptw_back.sv
rtl/four_level_page_table_walker.sv
rtl/ptw_checker.sv
bench/tb.sv
